// ===== src/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the point-to-segment distance block
// Holds the coordinate and fixed-point widths and the sideband records that
// travel through the divider and square-root pipelines.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Coordinate width and fraction bits of the projection offset.
	localparam int CoordBits = 16;
	localparam int FracBits  = 24;
	localparam int DistBits  = 25;

	// Derived widths.
	localparam int DiffBits = CoordBits + 1;
	localparam int ProdBits = 2 * DiffBits;
	localparam int Len2Bits = 2 * CoordBits + 2;
	localparam int DotBits  = ProdBits + 1;
	localparam int OffBits  = FracBits + 1;

	// Offset value of exactly one.
	localparam logic [OffBits-1:0] OffOne = OffBits'(1) << FracBits;

	// Geometry that rides along with the divider pipelines.
	typedef struct packed {
		logic signed [CoordBits-1:0] x1;
		logic signed [CoordBits-1:0] y1;
		logic signed [CoordBits-1:0] px;
		logic signed [CoordBits-1:0] py;
		logic signed [DiffBits-1:0]  dx;
		logic signed [DiffBits-1:0]  dy;
		logic                        len_zero;
		logic                        len_one;
	} geo_t;

	// Geometry plus the unclamped offset.
	typedef struct packed {
		geo_t               geo;
		logic [OffBits-1:0] u_raw;
	} geo_u_t;

endpackage

// ===== src/point_to_segment_distance_top.sv =====
`timescale 1ns / 1ps
// Pipeline at defaults, from input beat to output beat: 3 front stages,
// FracBits offset-divider stages, 2*FracBits bound-divider stages, FracBits
// bound-root stages, 6 clamp-to-square stages and DistBits distance-root stages.
// Throughput: one beat per cycle; every unit is fully pipelined, one result bit
// per stage. A stalled output freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// point_to_segment_distance_top: distance from a point to a line segment
// Projects the point onto the segment with a clamped Q0.24 offset, truncates
// the foot point to integers and returns the Euclidean distance in Q17.8.
// ----------------------------------------------------------------------------
module point_to_segment_distance_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_start_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_start_y,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_end_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_end_y,
	input  logic signed [pts_pkg::CoordBits-1:0]  point_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  point_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pts_pkg::DistBits-1:0]          dist_q8
);

	localparam int CW  = pts_pkg::CoordBits;
	localparam int FB  = pts_pkg::FracBits;
	localparam int DW  = pts_pkg::DiffBits;
	localparam int PW  = pts_pkg::ProdBits;
	localparam int LW  = pts_pkg::Len2Bits;
	localparam int OW  = pts_pkg::OffBits;
	localparam int GW  = $bits(pts_pkg::geo_t);
	localparam int GUW = $bits(pts_pkg::geo_u_t);
	localparam int MW  = OW + 1 + DW;
	localparam int NW  = MW + 1;
	localparam int SQW = 2 * pts_pkg::DistBits;

	logic en;

	// Whole pipeline advances unless the output beat is held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: differences.
	logic                 vld_s1;
	pts_pkg::geo_t        geo_s1;
	logic signed [DW-1:0] rx_s1, ry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.x1       <= seg_start_x;
			geo_s1.y1       <= seg_start_y;
			geo_s1.px       <= point_x;
			geo_s1.py       <= point_y;
			geo_s1.dx       <= DW'(seg_end_x) - DW'(seg_start_x);
			geo_s1.dy       <= DW'(seg_end_y) - DW'(seg_start_y);
			geo_s1.len_zero <= 1'b0;
			geo_s1.len_one  <= 1'b0;
			rx_s1           <= DW'(point_x) - DW'(seg_start_x);
			ry_s1           <= DW'(point_y) - DW'(seg_start_y);
		end
	end

	// Stage 2: products for the squared length and the dot product.
	logic                 vld_s2;
	pts_pkg::geo_t        geo_s2;
	logic signed [PW-1:0] ddx_s2, ddy_s2, pdx_s2, pdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			ddx_s2 <= geo_s1.dx * geo_s1.dx;
			ddy_s2 <= geo_s1.dy * geo_s1.dy;
			pdx_s2 <= rx_s1 * geo_s1.dx;
			pdy_s2 <= ry_s1 * geo_s1.dy;
		end
	end

	// Stage 3: squared length and dot product.
	logic                   vld_s3;
	pts_pkg::geo_t          geo_s3;
	logic [LW-1:0]          len2_s3;
	logic signed [LW:0]     dot_s3;
	logic [LW-1:0]          len2_sum;
	pts_pkg::geo_t          geo_flag;

	assign len2_sum = LW'(ddx_s2[PW-2:0]) + LW'(ddy_s2[PW-2:0]);

	// Geometry with the degenerate-length flags filled in.
	always_comb begin
		geo_flag          = geo_s2;
		geo_flag.len_zero = (len2_sum == '0);
		geo_flag.len_one  = (len2_sum == LW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3  <= geo_flag;
			len2_s3 <= len2_sum;
			dot_s3  <= (LW+1)'(pdx_s2) + (LW+1)'(pdy_s2);
		end
	end

	// Offset divider: u = dot * 2^FB / len2 where 0 < dot < len2.
	logic          dot_pos, dot_ge;
	logic [LW-1:0] div_a;
	logic          udiv_valid;
	logic [FB-1:0] udiv_q;
	logic [GW-1:0] udiv_side;
	logic [LW-1:0] udiv_len2;
	logic [1:0]    udiv_flags;

	assign dot_pos = !dot_s3[LW] && (dot_s3 != '0);
	assign dot_ge  = dot_pos && (dot_s3[LW-1:0] >= len2_s3);
	assign div_a   = (dot_pos && !dot_ge) ? dot_s3[LW-1:0] : '0;

	pts_div #(
		.BW(LW),
		.QW(FB),
		.SW(GW + LW + 2)
	) u_off_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.a        (div_a),
		.b        (len2_s3),
		.side_in  ({geo_s3, len2_s3, dot_pos, dot_ge}),
		.out_valid(udiv_valid),
		.q        (udiv_q),
		.side_out ({udiv_side, udiv_len2, udiv_flags})
	);

	// Unclamped offset with the out-of-range cases resolved.
	pts_pkg::geo_u_t geo_u;

	always_comb begin
		geo_u.geo = pts_pkg::geo_t'(udiv_side);
		if (geo_u.geo.len_zero || !udiv_flags[1]) begin
			geo_u.u_raw = '0;
		end else if (udiv_flags[0]) begin
			geo_u.u_raw = pts_pkg::OffOne;
		end else begin
			geo_u.u_raw = {1'b0, udiv_q};
		end
	end

	// Bound divider: 2^(2FB) / len2, then its square root.
	logic            bdiv_valid;
	logic [2*FB-1:0] bdiv_q;
	logic [GUW-1:0]  bdiv_side;
	logic            bsq_valid;
	logic [FB-1:0]   bsq_root;
	logic [GUW-1:0]  bsq_side;

	pts_div #(
		.BW(LW),
		.QW(2 * FB),
		.SW(GUW)
	) u_bound_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (udiv_valid),
		.a        (LW'(1)),
		.b        (udiv_len2),
		.side_in  (geo_u),
		.out_valid(bdiv_valid),
		.q        (bdiv_q),
		.side_out (bdiv_side)
	);

	pts_isqrt #(
		.IW(2 * FB),
		.SW(GUW)
	) u_bound_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (bdiv_valid),
		.n        (bdiv_q),
		.side_in  (bdiv_side),
		.out_valid(bsq_valid),
		.root     (bsq_root),
		.side_out (bsq_side)
	);

	// Stage 4: clamp the offset to [lbound, 1 - lbound]; a zero-length segment gets zero.
	pts_pkg::geo_u_t  gu_b;
	logic [OW-1:0]    lbound, ubound, u_lo, u_clamp;
	logic             vld_s4;
	pts_pkg::geo_t    geo_s4;
	logic [OW-1:0]    u_s4;

	assign gu_b    = pts_pkg::geo_u_t'(bsq_side);
	assign lbound  = gu_b.geo.len_one ? pts_pkg::OffOne : {1'b0, bsq_root};
	assign ubound  = pts_pkg::OffOne - lbound;
	assign u_lo    = (gu_b.u_raw < lbound) ? lbound : gu_b.u_raw;
	assign u_clamp = gu_b.geo.len_zero ? '0 : ((u_lo > ubound) ? ubound : u_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= bsq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4 <= gu_b.geo;
			u_s4   <= u_clamp;
		end
	end

	// Stage 5: offset times the segment direction.
	logic                 vld_s5;
	pts_pkg::geo_t        geo_s5;
	logic signed [MW-1:0] mx_s5, my_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5 <= geo_s4;
			mx_s5  <= $signed({1'b0, u_s4}) * geo_s4.dx;
			my_s5  <= $signed({1'b0, u_s4}) * geo_s4.dy;
		end
	end

	// Stage 6: foot point, truncated toward zero.
	logic signed [NW-1:0] numx, numy, magx, magy;
	logic [NW-FB-1:0]     shx, shy;
	logic                 vld_s6;
	pts_pkg::geo_t        geo_s6;
	logic signed [CW:0]   ix_s6, iy_s6;

	assign numx = $signed({geo_s5.x1, {FB{1'b0}}}) + NW'(mx_s5);
	assign numy = $signed({geo_s5.y1, {FB{1'b0}}}) + NW'(my_s5);
	assign magx = numx[NW-1] ? -numx : numx;
	assign magy = numy[NW-1] ? -numy : numy;
	assign shx  = magx[NW-1:FB];
	assign shy  = magy[NW-1:FB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6 <= geo_s5;
			ix_s6  <= numx[NW-1] ? -$signed(shx[CW:0]) : $signed(shx[CW:0]);
			iy_s6  <= numy[NW-1] ? -$signed(shy[CW:0]) : $signed(shy[CW:0]);
		end
	end

	// Stage 7: error vector.
	logic                 vld_s7;
	logic signed [CW+1:0] ex_s7, ey_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s7 <= (CW+2)'(geo_s6.px) - (CW+2)'(ix_s6);
			ey_s7 <= (CW+2)'(geo_s6.py) - (CW+2)'(iy_s6);
		end
	end

	// Stage 8: squares.
	logic                     vld_s8;
	logic signed [2*CW+3:0]   sqx_s8, sqy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s8 <= ex_s7 * ex_s7;
			sqy_s8 <= ey_s7 * ey_s7;
		end
	end

	// Stage 9: squared distance.
	logic                    vld_s9;
	logic [SQW-17:0]         d2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s9 <= (SQW-16)'(sqx_s8[2*CW+1:0]) + (SQW-16)'(sqy_s8[2*CW+1:0]);
		end
	end

	// Final square root of d2 * 2^16 gives the Q8 distance.
	logic [SQW-1:0] rad;
	logic           dist_side;

	assign rad = {d2_s9, 16'b0};

	pts_isqrt #(
		.IW(SQW),
		.SW(1)
	) u_dist_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s9),
		.n        (rad),
		.side_in  (1'b0),
		.out_valid(out_valid),
		.root     (dist_q8),
		.side_out (dist_side)
	);

`ifndef SYNTHESIS
	// The clamped offset never exceeds one.
	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (u_s4 <= pts_pkg::OffOne))
		else $error("clamped offset above one");

	// A zero-length segment always projects onto its start point.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && geo_s4.len_zero) |-> (u_s4 == '0))
		else $error("zero-length segment with nonzero offset");

	// A held pipeline keeps its middle stages intact.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_s5) |=> (vld_s5 && $stable(mx_s5) && $stable(my_s5)))
		else $error("pipeline stage changed while held");
`endif

endmodule

// ===== src/pts_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_div: pipelined fractional divider
// Computes floor(a * 2^QW / b) for a < b, one quotient bit per register
// stage, with a sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
module pts_div #(
	parameter int BW = 34,
	parameter int QW = 24,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [BW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] q,
	output logic [SW-1:0] side_out
);

	logic [BW-1:0] rem_s  [QW];
	logic [BW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic [QW-1:0] vld_s;

	// One restoring step per stage.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [BW-1:0] rem_in;
		logic [BW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [SW-1:0] side_k;
		logic          vld_in;
		logic [BW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = a;
			assign den_in = b;
			assign quo_in = '0;
			assign side_k = side_in;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign side_k = side_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		// Shift the remainder and try to subtract the divisor.
		assign trial = {rem_in, 1'b0};
		assign take  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? BW'(trial - {1'b0, den_in}) : trial[BW-1:0];
				den_s[k]  <= den_in;
				quo_s[k]  <= {quo_in[QW-2:0], take};
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign q         = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

// ===== src/pts_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_isqrt: pipelined integer square root
// Computes floor(sqrt(n)) for an IW-bit radicand, one root bit per register
// stage, with a sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
module pts_isqrt #(
	parameter int IW = 48,
	parameter int SW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [IW-1:0]      n,
	input  logic [SW-1:0]      side_in,
	output logic               out_valid,
	output logic [IW/2-1:0]    root,
	output logic [SW-1:0]      side_out
);

	localparam int RW = IW / 2;

	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [IW-1:0] rad_s  [RW];
	logic [SW-1:0] side_s [RW];
	logic [RW-1:0] vld_s;

	// One digit-by-digit step per stage.
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [IW-1:0] rad_in;
		logic [SW-1:0] side_k;
		logic          vld_in;
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = n;
			assign side_k  = side_in;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_k  = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// Bring down two radicand bits and test root*4 + 1.
		assign cur   = {rem_in[RW:0], rad_in[IW-1:IW-2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (RW+2)'(cur - trial) : cur[RW+1:0];
				root_s[k] <= {root_in[RW-2:0], take};
				rad_s[k]  <= {rad_in[IW-3:0], 2'b00};
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

// ===== tb/sv/pts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker: distance predictor and scoreboard for point_to_segment_distance
// Watches the input and output channels. Every accepted input beat is turned
// into an expected distance, and every accepted output beat is compared with
// the oldest expected distance in order.
// ----------------------------------------------------------------------------
module pts_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_start_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_start_y,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_end_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  seg_end_y,
	input  logic signed [pts_pkg::CoordBits-1:0]  point_x,
	input  logic signed [pts_pkg::CoordBits-1:0]  point_y,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [pts_pkg::DistBits-1:0]          dist_q8,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    dist_seen
);

	logic [pts_pkg::DistBits-1:0] dist_expected[$];

	// Integer square root, floor.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Distance from the point to the clamped projection foot, in Q17.8.
	function automatic logic [pts_pkg::DistBits-1:0] segment_distance(
		input longint x1, input longint y1, input longint x2, input longint y2,
		input longint px, input longint py);
		longint dx, dy, dot, u, lb, ub, ix, iy, ex, ey, num, one;
		logic [63:0] len2, d2;
		logic [127:0] wide;
		dx   = x2 - x1;
		dy   = y2 - y1;
		len2 = dx * dx + dy * dy;
		one  = longint'(1) << pts_pkg::FracBits;
		u    = 0;
		if (len2 != 0) begin
			dot = (px - x1) * dx + (py - y1) * dy;
			if (dot <= 0)
				u = 0;
			else if (64'(dot) >= len2)
				u = one;
			else
				u = longint'((128'(dot) << pts_pkg::FracBits) / len2);
			wide = (128'd1 << (2 * pts_pkg::FracBits)) / len2;
			lb = longint'(floor_sqrt(wide[63:0]));
			ub = one - lb;
			if (u < lb)
				u = lb;
			if (u > ub)
				u = ub;
		end
		num = x1 * one + u * dx;
		ix  = (num >= 0) ? (num >>> pts_pkg::FracBits) : -((-num) >>> pts_pkg::FracBits);
		num = y1 * one + u * dy;
		iy  = (num >= 0) ? (num >>> pts_pkg::FracBits) : -((-num) >>> pts_pkg::FracBits);
		ex  = px - ix;
		ey  = py - iy;
		d2  = ex * ex + ey * ey;
		return pts_pkg::DistBits'(floor_sqrt(d2 << 16));
	endfunction

	assign pending = dist_expected.size();

	// Predict on accepted input beats, compare on accepted output beats.
	always @(posedge clk or negedge arst_n) begin
		logic [pts_pkg::DistBits-1:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			dist_seen  <= 0;
			dist_expected.delete();
		end else begin
			if (in_valid && !in_stall)
				dist_expected.push_back(segment_distance(seg_start_x, seg_start_y,
					seg_end_x, seg_end_y, point_x, point_y));
			if (out_valid && !out_stall) begin
				dist_seen <= dist_seen + 1;
				if (dist_expected.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected distance beat: got %0d", dist_q8);
					fail_count <= fail_count + 1;
				end else begin
					want = dist_expected.pop_front();
					if (want !== dist_q8) begin
						if (fail_count < 10)
							$display("distance wrong: expected %0d, got %0d", want, dist_q8);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for point_to_segment_distance_top
// Sends directed corner geometries, then random segments and points under
// several idling phases and one long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [pts_pkg::CoordBits-1:0] seg_start_x = '0, seg_start_y = '0;
	logic signed [pts_pkg::CoordBits-1:0] seg_end_x = '0, seg_end_y = '0;
	logic signed [pts_pkg::CoordBits-1:0] point_x = '0, point_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [pts_pkg::DistBits-1:0] dist_q8;
	int fail_count, pending, dist_seen;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	int hold_cycles = 0;

	always #5 clk = ~clk;

	point_to_segment_distance_top dut (.*);

	pts_checker checker_i (.*);

	// Receiver: random stalls, or a long counted hold-off.
	always @(posedge clk) begin
		if (hold_off && hold_cycles < 400) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one beat and wait until it is taken. The stall is sampled mid-cycle,
	// where it holds the value seen at the next rising edge.
	task automatic send_query(input logic [15:0] ax, ay, bx, by, qx, qy);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		seg_start_x <= ax;
		seg_start_y <= ay;
		seg_end_x   <= bx;
		seg_end_y   <= by;
		point_x     <= qx;
		point_y     <= qy;
		@(negedge clk);
		while (in_stall) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Random coordinate: full range, extremes, or near a base value.
	function automatic logic [15:0] rand_coord(input logic [15:0] base);
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return base + 16'($signed($urandom_range(64)) - 32);
		endcase
	endfunction

	task automatic random_queries(input int count);
		logic [15:0] ax, ay;
		repeat (count) begin
			ax = 16'($urandom);
			ay = 16'($urandom);
			if ($urandom_range(4) == 0)
				send_query(ax, ay, ax + 16'($urandom_range(1)), ay, rand_coord(ax),
					rand_coord(ay));
			else
				send_query(ax, ay, rand_coord(ax), rand_coord(ay), rand_coord(ax),
					rand_coord(ay));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero length, unit length, extremes, projections off each end.
		send_query(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd4);
		send_query(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_query(16'd5, 16'd5, 16'd6, 16'd5, 16'd100, 16'hfff9);
		send_query(16'd5, 16'd5, 16'd5, 16'd6, 16'hff9c, 16'd70);
		send_query(16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd30);
		send_query(16'd0, 16'd0, 16'd100, 16'd0, 16'hffce, 16'd30);
		send_query(16'd0, 16'd0, 16'd100, 16'd0, 16'd150, 16'hffe2);
		send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_query(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_query(16'h8000, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'h7fff);
		send_query(16'hfff6, 16'hfff6, 16'd10, 16'd10, 16'd0, 16'd0);
		send_query(16'd3, 16'hfffc, 16'hfff7, 16'd12, 16'hffff, 16'h5555);
		send_query(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'haaaa, 16'haaaa);
		send_query(16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd2);

		// Phases: no idling, sender idle, receiver stall, both, then hold-off.
		random_queries(100);
		send_idle_pct = 53;
		random_queries(120);
		send_idle_pct = 0;
		stall_pct = 53;
		random_queries(120);
		send_idle_pct = 8;
		stall_pct = 8;
		random_queries(120);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 1'b1;
		random_queries(180);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d distances: directed corner geometries plus random", dist_seen);
		$display("segments under free flow, sender gaps, receiver stalls and a hold-off.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
